FILE: rtl/cfba_pkg.sv
// Shared constants and types for the chained free-block allocator.
package cfba_pkg;

    localparam int STACK_DEPTH = 100;
    localparam int BLOCK_COUNT = 1024;
    localparam int BLK_W       = $clog2(BLOCK_COUNT);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int WORD_W      = $clog2(STACK_DEPTH + 1);
    localparam int CHN_AW      = BLK_W + WORD_W;

    typedef enum logic
    {
        CMD_FREE  = 1'b0,
        CMD_ALLOC = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_POP,
        ST_SPILL,
        ST_LOAD_CNT,
        ST_LOAD
    } state_t;

    typedef struct packed
    {
        logic              we;
        logic [STK_AW-1:0] addr;
        logic [BLK_W-1:0]  wdata;
    } stk_req_t;

    typedef struct packed
    {
        logic              we;
        logic [CHN_AW-1:0] addr;
        logic [BLK_W-1:0]  wdata;
    } chn_req_t;

    typedef struct packed
    {
        logic             valid;
        logic [BLK_W-1:0] blk;
        logic             none;
    } res_t;

endpackage

FILE: rtl/cfba_ram.sv
// Single-port synchronous RAM with registered read data.
module cfba_ram #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cfba_seq.sv
// Sequencer: push/pop on the in-core stack, spill into and reload from chain storage.
module cfba_seq import cfba_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             cmd,
    input  logic [BLK_W-1:0] blk_in,
    output logic             idle,
    output stk_req_t         stk_req,
    input  logic [BLK_W-1:0] stk_rdata,
    output chn_req_t         chn_req,
    input  logic [BLK_W-1:0] chn_rdata,
    output res_t             res
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STK_AW-1:0]  idx_reg, idx_next;
    logic [BLK_W-1:0]   blk_reg, blk_next;
    logic               bot_valid_reg, bot_valid_next;

    logic [BLK_W-1:0]   stk_data;
    logic [STK_AW-1:0]  top_idx;
    logic [CNT_W-1:0]   load_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_W'(1);
            idx_reg       <= '0;
            blk_reg       <= '0;
            bot_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            blk_reg       <= blk_next;
            bot_valid_reg <= bot_valid_next;
        end
    end

    // entry 0 reads as the zero sentinel until it is first written
    always_comb
    begin
        top_idx = STK_AW'(count_reg - CNT_W'(1));
        if (state_reg == ST_POP)
        begin
            stk_data = (top_idx == '0 && !bot_valid_reg) ? '0 : stk_rdata;
        end
        else
        begin
            stk_data = (idx_reg == '0 && !bot_valid_reg) ? '0 : stk_rdata;
        end
        load_cnt = (chn_rdata > BLK_W'(STACK_DEPTH)) ? CNT_W'(STACK_DEPTH)
                                                     : chn_rdata[CNT_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        blk_next       = blk_reg;
        bot_valid_next = bot_valid_reg;
        stk_req        = '0;
        chn_req        = '0;
        res            = '0;
        idle           = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_FREE)
                    begin
                        if (count_reg >= CNT_W'(STACK_DEPTH))
                        begin
                            // full: count goes to word 0 of the freed block
                            chn_req.we    = 1'b1;
                            chn_req.addr  = {blk_in, WORD_W'(0)};
                            chn_req.wdata = BLK_W'(STACK_DEPTH);
                            stk_req.addr  = '0;
                            blk_next      = blk_in;
                            idx_next      = '0;
                            state_next    = ST_SPILL;
                        end
                        else
                        begin
                            stk_req.we    = 1'b1;
                            stk_req.addr  = STK_AW'(count_reg);
                            stk_req.wdata = blk_in;
                            count_next    = count_reg + CNT_W'(1);
                            if (count_reg == '0)
                            begin
                                bot_valid_next = 1'b1;
                            end
                            res.valid = 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res.valid = 1'b1;
                        res.none  = 1'b1;
                    end
                    else
                    begin
                        stk_req.addr = STK_AW'(count_reg - CNT_W'(1));
                        state_next   = ST_POP;
                    end
                end
            end

            ST_POP:
            begin
                if (stk_data == '0)
                begin
                    res.valid  = 1'b1;
                    res.none   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        blk_next     = stk_data;
                        chn_req.addr = {stk_data, WORD_W'(0)};
                        state_next   = ST_LOAD_CNT;
                    end
                    else
                    begin
                        res.valid  = 1'b1;
                        res.blk    = stk_data;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SPILL:
            begin
                chn_req.we    = 1'b1;
                chn_req.addr  = {blk_reg, WORD_W'(idx_reg) + WORD_W'(1)};
                chn_req.wdata = stk_data;
                if (idx_reg == STK_AW'(STACK_DEPTH - 1))
                begin
                    // stack restarts holding only the freed block
                    stk_req.we     = 1'b1;
                    stk_req.addr   = '0;
                    stk_req.wdata  = blk_reg;
                    count_next     = CNT_W'(1);
                    bot_valid_next = 1'b1;
                    res.valid      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    stk_req.addr = idx_reg + STK_AW'(1);
                    idx_next     = idx_reg + STK_AW'(1);
                end
            end

            ST_LOAD_CNT:
            begin
                count_next = load_cnt;
                if (load_cnt == '0)
                begin
                    res.valid  = 1'b1;
                    res.blk    = blk_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    chn_req.addr = {blk_reg, WORD_W'(1)};
                    idx_next     = '0;
                    state_next   = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                stk_req.we    = 1'b1;
                stk_req.addr  = idx_reg;
                stk_req.wdata = chn_rdata;
                if (idx_reg == '0)
                begin
                    bot_valid_next = 1'b1;
                end
                if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg)
                begin
                    res.valid  = 1'b1;
                    res.blk    = blk_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    chn_req.addr = {blk_reg, WORD_W'(idx_reg) + WORD_W'(2)};
                    idx_next     = idx_reg + STK_AW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/chained_free_block_allocator_unit.sv
// Paths: a free answers from idle and an allocate from ST_POP; a free on a full stack
// spills through ST_SPILL; an emptied stack reloads up to 100 entries via ST_LOAD_CNT, ST_LOAD.
// One item at a time: the sequencer and the single-port stack RAM bound the rate;
// the next item enters once the sequencer is idle and the output register is empty
// or its result is taken in the same cycle.
// Reset: count 1 with the zero sentinel at the bottom; no memory clearing pass.
module chained_free_block_allocator_unit import cfba_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] block_number, [15:10] zero
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] allocated_block, [15:10] zero
    output logic        m_tuser    // [0] none_left
);

    stk_req_t         stk_req;
    chn_req_t         chn_req;
    logic [BLK_W-1:0] stk_rdata;
    logic [BLK_W-1:0] chn_rdata;
    res_t             res;
    logic             idle;
    logic             start;

    logic             out_valid_reg, out_valid_next;
    logic [BLK_W-1:0] out_blk_reg, out_blk_next;
    logic             out_none_reg, out_none_next;

    assign s_tready = idle && (!out_valid_reg || m_tready);
    assign start    = s_tvalid && s_tready;

    cfba_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (s_tuser),
        .blk_in    (s_tdata[BLK_W-1:0]),
        .idle      (idle),
        .stk_req   (stk_req),
        .stk_rdata (stk_rdata),
        .chn_req   (chn_req),
        .chn_rdata (chn_rdata),
        .res       (res)
    );

    cfba_ram #(
        .ADDR_W (STK_AW),
        .DATA_W (BLK_W)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_req.we),
        .addr  (stk_req.addr),
        .wdata (stk_req.wdata),
        .rdata (stk_rdata)
    );

    cfba_ram #(
        .ADDR_W (CHN_AW),
        .DATA_W (BLK_W)
    ) u_chain_ram (
        .clk   (clk),
        .we    (chn_req.we),
        .addr  (chn_req.addr),
        .wdata (chn_req.wdata),
        .rdata (chn_rdata)
    );

    // output register: a new result only arrives once the previous one has left
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_blk_next   = out_blk_reg;
        out_none_next  = out_none_reg;
        if (res.valid)
        begin
            out_valid_next = 1'b1;
            out_blk_next   = res.blk;
            out_none_next  = res.none;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_blk_reg  <= out_blk_next;
        out_none_reg <= out_none_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - BLK_W){1'b0}}, out_blk_reg};
    assign m_tuser  = out_none_reg;

endmodule

FILE: test/tb.sv
// Testbench for the chained free-block allocator: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import cfba_pkg::*;

    typedef struct
    {
        cmd_t             cmd;
        logic [BLK_W-1:0] blk;
    } blk_cmd_t;

    typedef struct
    {
        logic [BLK_W-1:0] blk;
        logic             none;
    } blk_grant_t;

    localparam int QUIET_TAIL = 150;
    localparam int DRAIN_AT   = 950;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    // predictor state: in-core free stack and the per-block chain words
    logic [BLK_W-1:0] free_stack [STACK_DEPTH];
    int               free_count;
    logic [BLK_W-1:0] chain_mem [BLOCK_COUNT][STACK_DEPTH+1];

    blk_cmd_t   cmd_queue [$];
    blk_grant_t grant_queue [$];
    blk_cmd_t   offered;
    int         n_total  = 0;
    int         n_sent   = 0;
    int         n_recv   = 0;
    int         n_errors = 0;
    int         send_gap = 0;
    int         recv_gap = 0;

    chained_free_block_allocator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Applies one command to the free list and returns the grant it produces.
    function automatic blk_grant_t run_free_list(blk_cmd_t c);
        blk_grant_t       g;
        logic [BLK_W-1:0] popped;
        int               n;
        g.blk  = '0;
        g.none = 1'b0;
        if (c.cmd == CMD_FREE)
        begin
            if (free_count >= STACK_DEPTH)
            begin
                // full stack spills into the block being freed
                chain_mem[c.blk][0] = BLK_W'(STACK_DEPTH);
                for (int i = 0; i < STACK_DEPTH; i++)
                    chain_mem[c.blk][i+1] = free_stack[i];
                free_count = 0;
            end
            free_stack[free_count] = c.blk;
            free_count++;
        end
        else if (free_count == 0)
        begin
            g.none = 1'b1;
        end
        else
        begin
            popped = free_stack[free_count-1];
            if (popped == '0)
            begin
                // zero anywhere acts as end of chain; pop is undone
                g.none = 1'b1;
            end
            else
            begin
                free_count--;
                if (free_count == 0)
                begin
                    n = chain_mem[popped][0];
                    if (n > STACK_DEPTH)
                        n = STACK_DEPTH;
                    for (int i = 0; i < n; i++)
                        free_stack[i] = chain_mem[popped][i+1];
                    free_count = n;
                end
                g.blk = popped;
            end
        end
        return g;
    endfunction

    function automatic blk_cmd_t mk_cmd(cmd_t op, int blk);
        blk_cmd_t c;
        c.cmd = op;
        c.blk = BLK_W'(blk);
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin : drive
            logic next_valid;
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                grant_queue.push_back(run_free_list(offered));
                n_sent++;
                next_valid = 1'b0;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (n_sent < n_total - QUIET_TAIL && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(1, 6) - 1;
                end
                else if (cmd_queue.size() > 0
                         && !(n_sent == DRAIN_AT && grant_queue.size() != 0))
                begin
                    offered = cmd_queue.pop_front();
                    next_valid = 1'b1;
                    s_tdata <= {{(16-BLK_W){1'b0}}, offered.blk};
                    s_tuser <= offered.cmd;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin : check
            blk_grant_t want;
            logic       next_ready;
            if (m_tvalid && m_tready)
            begin
                if (grant_queue.size() == 0)
                begin
                    $error("unexpected item: allocated_block %0d none_left %0d",
                           m_tdata[BLK_W-1:0], m_tuser);
                    n_errors++;
                end
                else
                begin
                    want = grant_queue.pop_front();
                    if (m_tdata[BLK_W-1:0] !== want.blk)
                    begin
                        $error("allocated_block: expected %0d, actual %0d",
                               want.blk, m_tdata[BLK_W-1:0]);
                        n_errors++;
                    end
                    if (m_tdata[15:BLK_W] !== '0)
                    begin
                        $error("tdata padding: expected 0, actual %0h", m_tdata[15:BLK_W]);
                        n_errors++;
                    end
                    if (m_tuser !== want.none)
                    begin
                        $error("none_left: expected %0d, actual %0d", want.none, m_tuser);
                        n_errors++;
                    end
                end
                n_recv++;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                next_ready = 1'b0;
            end
            else if (n_recv < n_total - QUIET_TAIL && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 6) - 1;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
            end
            m_tready <= next_ready;
        end
    end

    // stimulus and end of run
    initial
    begin : stim
        int seg_len;
        int free_pct;
        int b;
        bit free_phase;
        for (int i = 0; i < STACK_DEPTH; i++)
            free_stack[i] = '0;
        free_count = 1;

        // directed: sentinel at reset, zero above the bottom, bit extremes
        cmd_queue.push_back(mk_cmd(CMD_ALLOC, 0));
        cmd_queue.push_back(mk_cmd(CMD_FREE, 1023));
        cmd_queue.push_back(mk_cmd(CMD_FREE, 0));
        cmd_queue.push_back(mk_cmd(CMD_ALLOC, 0));
        cmd_queue.push_back(mk_cmd(CMD_ALLOC, 1023));
        cmd_queue.push_back(mk_cmd(CMD_FREE, 682));
        cmd_queue.push_back(mk_cmd(CMD_FREE, 341));
        cmd_queue.push_back(mk_cmd(CMD_ALLOC, 682));
        cmd_queue.push_back(mk_cmd(CMD_ALLOC, 0));
        cmd_queue.push_back(mk_cmd(CMD_ALLOC, 0));
        cmd_queue.push_back(mk_cmd(CMD_FREE, 1));
        cmd_queue.push_back(mk_cmd(CMD_FREE, 512));
        cmd_queue.push_back(mk_cmd(CMD_ALLOC, 1023));
        cmd_queue.push_back(mk_cmd(CMD_ALLOC, 1023));
        cmd_queue.push_back(mk_cmd(CMD_ALLOC, 0));

        // random: alternating free-heavy and allocate-heavy runs to hit spills
        // and reloads; zero frees are rare since they wall off what is below
        free_phase = 1'b1;
        while (cmd_queue.size() < 1900)
        begin
            seg_len  = $urandom_range(40, 260);
            free_pct = free_phase ? $urandom_range(65, 95) : $urandom_range(5, 35);
            for (int i = 0; i < seg_len; i++)
            begin
                case ($urandom_range(0, 199))
                    0:       b = 0;
                    1, 2:    b = 1023;
                    default: b = $urandom_range(1, 1023);
                endcase
                cmd_queue.push_back(mk_cmd(
                    ($urandom_range(0, 99) < free_pct) ? CMD_FREE : CMD_ALLOC, b));
            end
            free_phase = ~free_phase;
        end
        n_total = cmd_queue.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (!(cmd_queue.size() == 0 && !s_tvalid && grant_queue.size() == 0))
            @(posedge clk);
        repeat (2 * STACK_DEPTH + 20) @(posedge clk);
        if (n_errors == 0 && grant_queue.size() == 0)
            $display("PASS chained_free_block_allocator_unit");
        else
            $display("FAIL chained_free_block_allocator_unit");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL chained_free_block_allocator_unit");
        $finish;
    end

endmodule
